[sv/aat_pkg.sv]
// ----------------------------------------------------------------------------
// Active alert table package
// Sizes, codes and the types shared between the table cells and the top level.
// ----------------------------------------------------------------------------
package aat_pkg;

    localparam int MAX_ACTIVE  = 8;
    localparam int ALERT_CODES = 64;
    localparam int TIME_BITS   = 32;

    localparam int IDX_W  = $clog2(MAX_ACTIVE);
    localparam int CNT_W  = $clog2(MAX_ACTIVE + 1);
    localparam int CODE_W = $clog2(ALERT_CODES);

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [CODE_W-1:0]    code_t;
    typedef logic [TIME_BITS-1:0] time_val_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED     = 3'd0,
        ST_RECOVERED    = 3'd1,
        ST_UNKNOWN_ALRT = 3'd2,
        ST_UNKNOWN_REC  = 3'd3,
        ST_NO_ACTIVE    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_REFRESH,
        CELL_DROP,
        CELL_SHIFT
    } cell_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RAISE_SCAN,
        S_RAISE_UPD,
        S_SUM,
        S_EMIT,
        S_REC_ADDR,
        S_REC_DATA,
        S_REC_DROP,
        S_COMPACT
    } state_t;

    typedef struct packed {
        logic      valid;
        code_t     code;
        logic [1:0] prio;
        time_val_t tstamp;
        logic [3:0] clr;
    } entry_t;

    // Command broadcast to every cell of the table.
    typedef struct packed {
        cell_op_t   op;
        code_t      code;
        logic [1:0] prio;
        time_val_t  tstamp;
        logic [3:0] clr;
    } cell_ctrl_t;

endpackage

[sv/aat_cell.sv]
// ----------------------------------------------------------------------------
// Active alert table cell
// Holds one table entry; loads, refreshes, drops or takes its right neighbour.
// ----------------------------------------------------------------------------
module aat_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  aat_pkg::cell_ctrl_t ctrl,
    input  logic                sel,
    input  aat_pkg::entry_t     right_in,
    input  logic                hole_in,
    output logic                hole_out,
    output logic                match,
    output aat_pkg::entry_t     entry
);

    aat_pkg::entry_t entry_reg, entry_next;

    assign match    = entry_reg.valid && (entry_reg.clr == ctrl.clr);
    // A cell moves left once any cell at or before it is empty.
    assign hole_out = hole_in || !entry_reg.valid;
    assign entry    = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        case (ctrl.op)
            aat_pkg::CELL_WRITE: begin
                if (sel) begin
                    entry_next.valid  = 1'b1;
                    entry_next.code   = ctrl.code;
                    entry_next.prio   = ctrl.prio;
                    entry_next.tstamp = ctrl.tstamp;
                    entry_next.clr    = ctrl.clr;
                end
            end
            aat_pkg::CELL_REFRESH: begin
                if (sel) begin
                    entry_next.prio   = ctrl.prio;
                    entry_next.tstamp = ctrl.tstamp;
                end
            end
            aat_pkg::CELL_DROP: begin
                if (match) begin
                    entry_next.valid = 1'b0;
                end
            end
            aat_pkg::CELL_SHIFT: begin
                if (hole_out) begin
                    entry_next = right_in;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
        end else begin
            entry_reg <= entry_next;
        end
    end

endmodule

[sv/active_alert_table.sv]
// ----------------------------------------------------------------------------
// Active alert table
// Table of active alerts with a saturating repeat counter per alert code.
// ----------------------------------------------------------------------------
// The entries sit in a row of cells that is always packed from slot 0. A raise
// word scans the row one slot a cycle, updates one cell, then scans again for
// the summary. A recover word scans for the summary and, if any entry holds
// its recovery code, walks the row once more, reading the counter memory for
// each cleared entry and sending its result, which may wait on the output;
// it then drops the cleared entries and compacts the row. Rejected words go
// straight to their result. A new word is taken only once the previous one
// is finished, while its last result may still wait on the output.
module active_alert_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] alert_code, [9:8] alert_priority, [13:10] recovery_code,
    // [45:14] time_ms, [47:46] zero
    input  logic [47:0] s_tdata,
    // [0] req_type
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [5:0] result_code, [37:6] repeat_count, [39:38] highest_priority,
    // [43:40] active_count, [47:44] zero
    output logic [47:0] m_tdata,
    // [2:0] status
    output logic [2:0]  m_tuser,
    // last_result
    output logic        m_tlast
);

    localparam int N = aat_pkg::MAX_ACTIVE;

    aat_pkg::state_t state_reg, state_next;

    // Request registers
    logic              rec_reg;
    logic [7:0]        code_in_reg;
    logic [1:0]        prio_reg;
    logic [3:0]        clr_reg;
    aat_pkg::time_val_t time_reg;

    aat_pkg::idx_t     idx_reg;
    logic              hit_reg;
    aat_pkg::idx_t     hit_idx_reg;
    aat_pkg::idx_t     cand_reg;
    aat_pkg::cnt_t     acc_n_reg, match_n_reg, sent_reg;
    logic [1:0]        acc_hi_reg;
    logic [1:0]        top_reg;
    aat_pkg::cnt_t     count_reg;

    aat_pkg::status_t  res_status_reg;
    logic [31:0]       res_cnt_reg;

    // Output register
    logic              out_valid_reg;
    aat_pkg::status_t  out_status_reg;
    logic [5:0]        out_code_reg;
    logic [31:0]       out_cnt_reg;
    logic [1:0]        out_hi_reg;
    logic [3:0]        out_ac_reg;
    logic              out_last_reg;
    logic              out_load;

    // Counter memory with one valid bit per code
    logic [31:0]       cnt_mem [aat_pkg::ALERT_CODES];
    logic [aat_pkg::ALERT_CODES-1:0] cnt_vld_reg;
    logic [31:0]       rd_data_reg;
    logic              rd_en;
    aat_pkg::code_t    rd_addr;
    logic              wr_en;
    logic [31:0]       wr_data;

    // Cell row
    aat_pkg::cell_ctrl_t ctrl;
    logic [N-1:0]        sel;
    aat_pkg::entry_t     entries [N];
    aat_pkg::entry_t     right_in [N];
    logic [N:0]          holes;
    logic [N-1:0]        match_vec;

    aat_pkg::entry_t cur;
    logic            cur_match, cur_alive, last_idx, out_free;
    aat_pkg::code_t  req_code;
    aat_pkg::idx_t   slot;
    logic [1:0]      sum_hi;
    aat_pkg::cnt_t   sum_n, sum_m;
    logic [1:0]      in_prio;

    assign holes[0] = 1'b0;

    for (genvar i = 0; i < N; i++) begin : g_cell
        if (i == N - 1) begin : g_tail
            assign right_in[i] = '0;
        end else begin : g_mid
            assign right_in[i] = entries[i+1];
        end
        aat_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .sel      (sel[i]),
            .right_in (right_in[i]),
            .hole_in  (holes[i]),
            .hole_out (holes[i+1]),
            .match    (match_vec[i]),
            .entry    (entries[i])
        );
    end

    assign cur       = entries[idx_reg];
    assign cur_match = match_vec[idx_reg];
    assign cur_alive = cur.valid && !(rec_reg && cur_match);
    assign last_idx  = (idx_reg == aat_pkg::idx_t'(N - 1));
    assign out_free  = !out_valid_reg || m_tready;
    assign req_code  = aat_pkg::code_t'(code_in_reg);
    assign in_prio   = (s_tdata[9:8] == 2'd3) ? 2'd0 : s_tdata[9:8];
    assign out_load  = out_free && ((state_reg == aat_pkg::S_EMIT) ||
                                    (state_reg == aat_pkg::S_REC_DATA));

    // Hit slot, else free slot at the fill level (packed row), else candidate.
    always_comb begin
        if (hit_reg) begin
            slot = hit_idx_reg;
        end else if (count_reg < aat_pkg::cnt_t'(N)) begin
            slot = aat_pkg::idx_t'(count_reg);
        end else begin
            slot = cand_reg;
        end
    end

    always_comb begin
        sum_hi = (cur_alive && cur.prio > acc_hi_reg) ? cur.prio : acc_hi_reg;
        sum_n  = acc_n_reg + aat_pkg::cnt_t'(cur_alive);
        sum_m  = match_n_reg + aat_pkg::cnt_t'(cur.valid && cur_match);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            aat_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser[0]) begin
                        state_next = (s_tdata[13:10] == 4'd0) ? aat_pkg::S_EMIT
                                                              : aat_pkg::S_SUM;
                    end else if (32'(s_tdata[7:0]) >= aat_pkg::ALERT_CODES) begin
                        state_next = aat_pkg::S_EMIT;
                    end else begin
                        state_next = aat_pkg::S_RAISE_SCAN;
                    end
                end
            end
            aat_pkg::S_RAISE_SCAN: begin
                if (last_idx) state_next = aat_pkg::S_RAISE_UPD;
            end
            aat_pkg::S_RAISE_UPD: begin
                state_next = aat_pkg::S_SUM;
            end
            aat_pkg::S_SUM: begin
                if (last_idx) begin
                    if (rec_reg && sum_m != '0) begin
                        state_next = aat_pkg::S_REC_ADDR;
                    end else begin
                        state_next = aat_pkg::S_EMIT;
                    end
                end
            end
            aat_pkg::S_EMIT: begin
                if (out_free) state_next = aat_pkg::S_IDLE;
            end
            aat_pkg::S_REC_ADDR: begin
                if (cur_match) begin
                    state_next = aat_pkg::S_REC_DATA;
                end else if (last_idx) begin
                    state_next = aat_pkg::S_REC_DROP;
                end
            end
            aat_pkg::S_REC_DATA: begin
                if (out_free) begin
                    state_next = last_idx ? aat_pkg::S_REC_DROP : aat_pkg::S_REC_ADDR;
                end
            end
            aat_pkg::S_REC_DROP: begin
                state_next = aat_pkg::S_COMPACT;
            end
            aat_pkg::S_COMPACT: begin
                if (last_idx || !holes[N]) state_next = aat_pkg::S_IDLE;
            end
            default: begin
                state_next = aat_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_tready    = 1'b0;
        ctrl.op     = aat_pkg::CELL_HOLD;
        ctrl.code   = req_code;
        ctrl.prio   = prio_reg;
        ctrl.tstamp = time_reg;
        ctrl.clr    = clr_reg;
        sel         = '0;
        rd_en       = 1'b0;
        rd_addr     = req_code;
        wr_en       = 1'b0;
        wr_data     = (rd_data_reg == 32'hFFFF_FFFF) ? rd_data_reg : rd_data_reg + 32'd1;
        case (state_reg)
            aat_pkg::S_IDLE: begin
                s_tready = 1'b1;
            end
            aat_pkg::S_RAISE_SCAN: begin
                rd_en = 1'b1;
            end
            aat_pkg::S_RAISE_UPD: begin
                ctrl.op    = hit_reg ? aat_pkg::CELL_REFRESH : aat_pkg::CELL_WRITE;
                sel[slot]  = 1'b1;
                wr_en      = 1'b1;
            end
            aat_pkg::S_REC_ADDR: begin
                rd_en   = 1'b1;
                rd_addr = cur.code;
            end
            aat_pkg::S_REC_DROP: begin
                ctrl.op = aat_pkg::CELL_DROP;
            end
            aat_pkg::S_COMPACT: begin
                ctrl.op = aat_pkg::CELL_SHIFT;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_vld_reg <= '0;
        end else if (wr_en) begin
            cnt_vld_reg[req_code] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cnt_mem[req_code] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= cnt_vld_reg[rd_addr] ? cnt_mem[rd_addr] : 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= aat_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            top_reg       <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                aat_pkg::S_IDLE: begin
                    idx_reg     <= '0;
                    hit_reg     <= 1'b0;
                    cand_reg    <= '0;
                    acc_n_reg   <= '0;
                    acc_hi_reg  <= '0;
                    match_n_reg <= '0;
                    sent_reg    <= '0;
                    res_cnt_reg <= '0;
                    if (s_tvalid) begin
                        rec_reg     <= s_tuser[0];
                        code_in_reg <= s_tdata[7:0];
                        prio_reg    <= in_prio;
                        clr_reg     <= s_tdata[13:10];
                        time_reg    <= aat_pkg::time_val_t'(s_tdata[45:14]);
                        if (s_tuser[0]) begin
                            res_status_reg <= aat_pkg::ST_UNKNOWN_REC;
                        end else begin
                            res_status_reg <= aat_pkg::ST_UNKNOWN_ALRT;
                        end
                    end
                end
                aat_pkg::S_RAISE_SCAN: begin
                    if (!hit_reg && cur.valid && cur.code == req_code) begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= idx_reg;
                    end
                    if (idx_reg != '0) begin
                        if (cur.prio < entries[cand_reg].prio ||
                            (cur.prio == entries[cand_reg].prio &&
                             cur.tstamp < entries[cand_reg].tstamp)) begin
                            cand_reg <= idx_reg;
                        end
                    end
                    idx_reg <= last_idx ? '0 : idx_reg + aat_pkg::idx_t'(1);
                end
                aat_pkg::S_RAISE_UPD: begin
                    res_cnt_reg    <= wr_data;
                    res_status_reg <= aat_pkg::ST_ACCEPTED;
                end
                aat_pkg::S_SUM: begin
                    acc_hi_reg  <= sum_hi;
                    acc_n_reg   <= sum_n;
                    match_n_reg <= sum_m;
                    idx_reg     <= last_idx ? '0 : idx_reg + aat_pkg::idx_t'(1);
                    if (last_idx) begin
                        if (!rec_reg || sum_m != '0) begin
                            top_reg   <= sum_hi;
                            count_reg <= sum_n;
                        end
                        if (rec_reg) res_status_reg <= aat_pkg::ST_NO_ACTIVE;
                    end
                end
                aat_pkg::S_EMIT: begin
                    if (out_free) begin
                        out_status_reg <= res_status_reg;
                        out_code_reg   <= (res_status_reg == aat_pkg::ST_ACCEPTED) ?
                                          6'(req_code) : 6'd0;
                        out_cnt_reg    <= res_cnt_reg;
                        out_hi_reg     <= top_reg;
                        out_ac_reg     <= 4'(count_reg);
                        out_last_reg   <= 1'b1;
                    end
                end
                aat_pkg::S_REC_ADDR: begin
                    if (!cur_match && !last_idx) idx_reg <= idx_reg + aat_pkg::idx_t'(1);
                    if (!cur_match && last_idx) idx_reg <= '0;
                end
                aat_pkg::S_REC_DATA: begin
                    if (out_free) begin
                        out_status_reg <= aat_pkg::ST_RECOVERED;
                        out_code_reg   <= 6'(cur.code);
                        out_cnt_reg    <= rd_data_reg;
                        out_hi_reg     <= top_reg;
                        out_ac_reg     <= 4'(count_reg);
                        out_last_reg   <= (sent_reg + aat_pkg::cnt_t'(1) == match_n_reg);
                        sent_reg       <= sent_reg + aat_pkg::cnt_t'(1);
                        idx_reg        <= last_idx ? '0 : idx_reg + aat_pkg::idx_t'(1);
                    end
                end
                aat_pkg::S_COMPACT: begin
                    idx_reg <= last_idx ? '0 : idx_reg + aat_pkg::idx_t'(1);
                end
                default: begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'd0, out_ac_reg, out_hi_reg, out_cnt_reg, out_code_reg};

endmodule
